>>> rtl/core/lhp_pkg.sv
// shared types, constants and bucket edge functions of the latency histogram
`default_nettype none
package lhp_pkg;

  localparam int NUM_BUCKETS = 13;

  localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
  localparam logic [29:0] BILLION   = 30'd1000000000;
  localparam logic [13:0] PCT_FULL  = 14'd10000;
  localparam logic [30:0] RESET_MAX = 31'd3600000;
  localparam logic [38:0] MAX39     = 39'h7F_FFFF_FFFF;
  localparam logic [5:0]  VAL_BITS  = 6'd39;

  typedef enum logic [1:0] {
    OP_REC,
    OP_CLR,
    OP_RD,
    OP_PCT
  } op_t;

  typedef struct packed {
    op_t         kind;
    logic        keep;
    logic [3:0]  bkt;
    logic [30:0] delay;
    logic [3:0]  idx;
    logic [13:0] pct;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROLL,
    ST_MMUL,
    ST_MADD,
    ST_MCHK,
    ST_MDIV,
    ST_PMUL,
    ST_PCMP,
    ST_PSET,
    ST_FRAC,
    ST_OUT
  } state_t;

  function automatic logic [12:0] edge_of(input logic [3:0] i);
    logic [12:0] e;
    case (i)
      4'd0:    e = 13'd1;
      4'd1:    e = 13'd2;
      4'd2:    e = 13'd5;
      4'd3:    e = 13'd10;
      4'd4:    e = 13'd25;
      4'd5:    e = 13'd50;
      4'd6:    e = 13'd100;
      4'd7:    e = 13'd250;
      4'd8:    e = 13'd500;
      4'd9:    e = 13'd1000;
      4'd10:   e = 13'd2500;
      4'd11:   e = 13'd5000;
      default: e = 13'd0;
    endcase
    return e;
  endfunction

  function automatic logic [3:0] bucket_of(input logic [30:0] ms);
    logic [3:0] b;
    b = 4'(NUM_BUCKETS - 1);
    for (int k = NUM_BUCKETS - 2; k >= 0; k--) begin
      if (ms <= {18'd0, edge_of(4'(k))}) begin
        b = 4'(k);
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/lhp_front.sv
// front end: limit register, command classification and bucket selection
`default_nettype none
module lhp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    in_kind,
  input  wire logic [31:0]   in_delay_ms,
  input  wire logic [3:0]    in_bucket_index,
  input  wire logic [13:0]   in_pct_hundredths,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [30:0]   cfg_max_delay_ms,
  input  wire logic          q_full,
  output logic               q_push,
  output lhp_pkg::cmd_t      q_cmd
);

  logic [30:0] max_r;
  logic [30:0] max_nxt;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign q_push    = start && !q_full;

  always_comb begin
    max_nxt = max_r;
    if (cfg_valid && cfg_ready) begin
      max_nxt = cfg_max_delay_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= lhp_pkg::RESET_MAX;
    end else begin
      max_r <= max_nxt;
    end
  end

  always_comb begin
    q_cmd.kind  = lhp_pkg::op_t'(in_kind);
    q_cmd.keep  = (in_delay_ms <= {1'b0, max_r});
    q_cmd.bkt   = lhp_pkg::bucket_of(in_delay_ms[30:0]);
    q_cmd.delay = in_delay_ms[30:0];
    q_cmd.idx   = in_bucket_index;
    q_cmd.pct   = (in_pct_hundredths > lhp_pkg::PCT_FULL) ? lhp_pkg::PCT_FULL
                                                          : in_pct_hundredths;
  end

endmodule
`default_nettype wire

>>> rtl/core/lhp_queue.sv
// two-entry command queue between front and back
`default_nettype none
module lhp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lhp_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               valid,
  input  wire logic          pop,
  output lhp_pkg::cmd_t      head
);

  lhp_pkg::cmd_t mem_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lhp_back.sv
// back end: histogram stores, bucket scan, interpolation and mean divider
`default_nettype none
module lhp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire lhp_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  output logic               out_accepted,
  output logic [31:0]        out_sample_count,
  output logic [30:0]        out_min_delay,
  output logic [30:0]        out_max_delay,
  output logic [29:0]        out_sum_low_part,
  output logic [31:0]        out_sum_high_part,
  output logic [31:0]        out_bucket_count,
  output logic [12:0]        out_bucket_upper,
  output logic [38:0]        out_percentile_value,
  output logic [38:0]        out_mean_value
);

  lhp_pkg::state_t state_r, state_nxt;
  lhp_pkg::op_t    kind_r, kind_nxt;

  logic [31:0] bcnt_r [lhp_pkg::NUM_BUCKETS];
  logic [31:0] bcnt_nxt [lhp_pkg::NUM_BUCKETS];
  logic [31:0] total_r, total_nxt;
  logic [30:0] min_r, min_nxt;
  logic [30:0] max_r, max_nxt;
  logic [29:0] low_r, low_nxt;
  logic [31:0] roll_r, roll_nxt;
  logic [38:0] mean_r, mean_nxt;
  logic        acc_r, acc_nxt;
  logic [31:0] bco_r, bco_nxt;
  logic [12:0] buo_r, buo_nxt;
  logic [38:0] pval_r, pval_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [61:0] prod_r, prod_nxt;
  logic [46:0] rem_r, rem_nxt;
  logic [38:0] sh_r, sh_nxt;
  logic [38:0] res_r, res_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [3:0]  i_r, i_nxt;
  logic [45:0] tgt_r, tgt_nxt;
  logic [49:0] cum_r, cum_nxt;
  logic [45:0] num_r, num_nxt;
  logic [45:0] den_r, den_nxt;
  logic [30:0] lo_r, lo_nxt;
  logic        ph_r, ph_nxt;

  logic        roll_ge;
  logic        ovf;
  logic        cz;
  logic        hit;
  logic        last_i;
  logic [49:0] cum_add;

  assign roll_ge = (sum_r >= {2'b00, lhp_pkg::BILLION});
  assign ovf     = ({1'b0, prod_r[61:31]} >= total_r);
  assign cz      = (prod_r[45:0] == 46'd0);
  assign cum_add = cum_r + {4'd0, prod_r[45:0]};
  assign hit     = (cum_add >= {4'd0, tgt_r});
  assign last_i  = (i_r == 4'(lhp_pkg::NUM_BUCKETS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lhp_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            lhp_pkg::OP_REC: state_nxt = q_cmd.keep ? lhp_pkg::ST_ROLL : lhp_pkg::ST_OUT;
            lhp_pkg::OP_PCT: state_nxt = (total_r == 32'd0) ? lhp_pkg::ST_OUT
                                                            : lhp_pkg::ST_PMUL;
            default:         state_nxt = lhp_pkg::ST_OUT;
          endcase
        end
      end
      lhp_pkg::ST_ROLL: state_nxt = roll_ge ? lhp_pkg::ST_ROLL : lhp_pkg::ST_MMUL;
      lhp_pkg::ST_MMUL: state_nxt = lhp_pkg::ST_MADD;
      lhp_pkg::ST_MADD: state_nxt = lhp_pkg::ST_MCHK;
      lhp_pkg::ST_MCHK: state_nxt = ovf ? lhp_pkg::ST_OUT : lhp_pkg::ST_MDIV;
      lhp_pkg::ST_MDIV: state_nxt = (cnt_r == 6'd1) ? lhp_pkg::ST_OUT : lhp_pkg::ST_MDIV;
      lhp_pkg::ST_PMUL: state_nxt = lhp_pkg::ST_PCMP;
      lhp_pkg::ST_PCMP: begin
        if (!cz && hit) begin
          state_nxt = lhp_pkg::ST_PSET;
        end else if (last_i) begin
          state_nxt = lhp_pkg::ST_OUT;
        end else begin
          state_nxt = lhp_pkg::ST_PMUL;
        end
      end
      lhp_pkg::ST_PSET: state_nxt = lhp_pkg::ST_FRAC;
      lhp_pkg::ST_FRAC: state_nxt = (ph_r && cnt_r == 6'd1) ? lhp_pkg::ST_OUT
                                                             : lhp_pkg::ST_FRAC;
      lhp_pkg::ST_OUT:  state_nxt = lhp_pkg::ST_IDLE;
      default:          state_nxt = lhp_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      lhp_pkg::ST_IDLE: q_pop = q_valid;
      lhp_pkg::ST_OUT:  out_valid = 1'b1;
      default: begin
        q_pop     = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    logic [30:0] lo_v;
    logic [30:0] hi_v;
    logic [12:0] e_v;
    logic [45:0] num_v;
    logic [32:0] t33;
    logic [46:0] t47;
    logic [38:0] rs;
    logic        qb;

    kind_nxt  = kind_r;
    bcnt_nxt  = bcnt_r;
    total_nxt = total_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    low_nxt   = low_r;
    roll_nxt  = roll_r;
    mean_nxt  = mean_r;
    acc_nxt   = acc_r;
    bco_nxt   = bco_r;
    buo_nxt   = buo_r;
    pval_nxt  = pval_r;
    sum_nxt   = sum_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    tgt_nxt   = tgt_r;
    cum_nxt   = cum_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    lo_nxt    = lo_r;
    ph_nxt    = ph_r;
    lo_v      = 31'd0;
    hi_v      = 31'd0;
    e_v       = 13'd0;
    num_v     = 46'd0;
    t33       = 33'd0;
    t47       = 47'd0;
    rs        = 39'd0;
    qb        = 1'b0;

    case (state_r)
      lhp_pkg::ST_IDLE: begin
        if (q_valid) begin
          kind_nxt = q_cmd.kind;
          acc_nxt  = 1'b0;
          bco_nxt  = 32'd0;
          buo_nxt  = 13'd0;
          pval_nxt = 39'd0;
          case (q_cmd.kind)
            lhp_pkg::OP_REC: begin
              acc_nxt = q_cmd.keep;
              if (q_cmd.keep) begin
                if (bcnt_r[q_cmd.bkt] != lhp_pkg::SAT32) begin
                  bcnt_nxt[q_cmd.bkt] = bcnt_r[q_cmd.bkt] + 32'd1;
                end
                if (total_r != lhp_pkg::SAT32) begin
                  total_nxt = total_r + 32'd1;
                end
                if (total_r == 32'd0 || q_cmd.delay < min_r) begin
                  min_nxt = q_cmd.delay;
                end
                if (q_cmd.delay > max_r) begin
                  max_nxt = q_cmd.delay;
                end
                sum_nxt = {2'b00, low_r} + {1'b0, q_cmd.delay};
              end
            end
            lhp_pkg::OP_CLR: begin
              for (int k = 0; k < lhp_pkg::NUM_BUCKETS; k++) begin
                bcnt_nxt[k] = 32'd0;
              end
              total_nxt = 32'd0;
              min_nxt   = 31'd0;
              max_nxt   = 31'd0;
              low_nxt   = 30'd0;
              roll_nxt  = 32'd0;
              mean_nxt  = 39'd0;
            end
            lhp_pkg::OP_RD: begin
              if (q_cmd.idx < 4'(lhp_pkg::NUM_BUCKETS)) begin
                bco_nxt = bcnt_r[q_cmd.idx];
                buo_nxt = lhp_pkg::edge_of(q_cmd.idx);
              end
            end
            lhp_pkg::OP_PCT: begin
              tgt_nxt = 46'({14'd0, total_r} * {32'd0, q_cmd.pct});
              i_nxt   = 4'd0;
              cum_nxt = 50'd0;
            end
            default: begin
              acc_nxt = 1'b0;
            end
          endcase
        end
      end
      lhp_pkg::ST_ROLL: begin
        if (roll_ge) begin
          sum_nxt = sum_r - {2'b00, lhp_pkg::BILLION};
          if (roll_r != lhp_pkg::SAT32) begin
            roll_nxt = roll_r + 32'd1;
          end
        end else begin
          low_nxt = sum_r[29:0];
        end
      end
      lhp_pkg::ST_MMUL: begin
        prod_nxt = {30'd0, roll_r} * {32'd0, lhp_pkg::BILLION};
      end
      lhp_pkg::ST_MADD: begin
        prod_nxt = prod_r + {32'd0, low_r};
      end
      lhp_pkg::ST_MCHK: begin
        if (ovf) begin
          mean_nxt = lhp_pkg::MAX39;
        end else begin
          rem_nxt = {16'd0, prod_r[61:31]};
          sh_nxt  = {prod_r[30:0], 8'd0};
          cnt_nxt = lhp_pkg::VAL_BITS;
        end
      end
      lhp_pkg::ST_MDIV: begin
        t33 = {rem_r[31:0], sh_r[38]};
        if (t33 >= {1'b0, total_r}) begin
          t33 = t33 - {1'b0, total_r};
          qb  = 1'b1;
        end
        rem_nxt = {14'd0, t33};
        sh_nxt  = {sh_r[37:0], qb};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          mean_nxt = {sh_r[37:0], qb};
        end
      end
      lhp_pkg::ST_PMUL: begin
        prod_nxt = {16'd0, 46'({14'd0, bcnt_r[i_r]} * {32'd0, lhp_pkg::PCT_FULL})};
      end
      lhp_pkg::ST_PCMP: begin
        if (!cz && hit) begin
          den_nxt = prod_r[45:0];
        end else begin
          cum_nxt = cum_add;
          i_nxt   = i_r + 4'd1;
          if (last_i) begin
            pval_nxt = {max_r, 8'd0};
          end
        end
      end
      lhp_pkg::ST_PSET: begin
        lo_v = (i_r == 4'd0) ? 31'd0 : {18'd0, lhp_pkg::edge_of(i_r - 4'd1)};
        e_v  = lhp_pkg::edge_of(i_r);
        hi_v = (e_v != 13'd0) ? {18'd0, e_v} : max_r;
        if (lo_v < min_r) lo_v = min_r;
        if (hi_v > max_r) hi_v = max_r;
        if (hi_v < lo_v) hi_v = lo_v;
        num_v = ({4'd0, tgt_r} > cum_r) ? (tgt_r - cum_r[45:0]) : 46'd0;
        if (num_v > den_r) num_v = den_r;
        num_nxt = num_v;
        lo_nxt  = lo_v;
        sh_nxt  = {hi_v - lo_v, 8'd0};
        rem_nxt = 47'd0;
        res_nxt = 39'd0;
        cnt_nxt = lhp_pkg::VAL_BITS;
        ph_nxt  = 1'b0;
      end
      lhp_pkg::ST_FRAC: begin
        if (!ph_r) begin
          t47 = {rem_r[45:0], 1'b0};
          if (t47 >= {1'b0, den_r}) begin
            t47 = t47 - {1'b0, den_r};
            qb  = 1'b1;
          end
          rem_nxt = t47;
          res_nxt = {res_r[37:0], qb};
          ph_nxt  = 1'b1;
        end else begin
          t47 = rem_r;
          rs  = res_r;
          if (sh_r[38]) begin
            t47 = rem_r + {1'b0, num_r};
            if (t47 >= {1'b0, den_r}) begin
              t47 = t47 - {1'b0, den_r};
              rs  = res_r + 39'd1;
            end
          end
          rem_nxt = t47;
          res_nxt = rs;
          sh_nxt  = {sh_r[37:0], 1'b0};
          cnt_nxt = cnt_r - 6'd1;
          ph_nxt  = 1'b0;
          if (cnt_r == 6'd1) begin
            pval_nxt = {lo_r, 8'd0} + rs;
          end
        end
      end
      default: begin
        kind_nxt = kind_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lhp_pkg::ST_IDLE;
      kind_r  <= lhp_pkg::OP_REC;
      for (int k = 0; k < lhp_pkg::NUM_BUCKETS; k++) begin
        bcnt_r[k] <= 32'd0;
      end
      total_r <= 32'd0;
      min_r   <= 31'd0;
      max_r   <= 31'd0;
      low_r   <= 30'd0;
      roll_r  <= 32'd0;
      mean_r  <= 39'd0;
      acc_r   <= 1'b0;
      bco_r   <= 32'd0;
      buo_r   <= 13'd0;
      pval_r  <= 39'd0;
      ph_r    <= 1'b0;
      cnt_r   <= 6'd0;
      i_r     <= 4'd0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      bcnt_r  <= bcnt_nxt;
      total_r <= total_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      low_r   <= low_nxt;
      roll_r  <= roll_nxt;
      mean_r  <= mean_nxt;
      acc_r   <= acc_nxt;
      bco_r   <= bco_nxt;
      buo_r   <= buo_nxt;
      pval_r  <= pval_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    res_r  <= res_nxt;
    tgt_r  <= tgt_nxt;
    cum_r  <= cum_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    lo_r   <= lo_nxt;
  end

  assign out_accepted         = acc_r;
  assign out_sample_count     = total_r;
  assign out_min_delay        = min_r;
  assign out_max_delay        = max_r;
  assign out_sum_low_part     = low_r;
  assign out_sum_high_part    = roll_r;
  assign out_bucket_count     = bco_r;
  assign out_bucket_upper     = buo_r;
  assign out_percentile_value = pval_r;
  assign out_mean_value       = mean_r;

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_low_below_billion: assert property (@(posedge clk) disable iff (!rst_n)
    low_r < lhp_pkg::BILLION) else $error("sum low part out of range");

  a_accept_only_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (kind_r == lhp_pkg::OP_REC))
    else $error("accepted flag on non-record");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r == 32'd0) |-> (min_r == 31'd0 && max_r == 31'd0 && mean_r == 39'd0))
    else $error("empty histogram with nonzero status");

endmodule
`default_nettype wire

>>> rtl/core/latency_histogram_percentile.sv
// top level of the latency histogram with percentile estimate
// One command is taken when start is high and busy is low; a two-entry queue
// lets up to two commands wait while the back end works. Every command gives
// exactly one result, shown for one cycle with out_valid, and the receiver
// cannot stall it. Time per command is set by the back end sequencer: clear
// and bucket read go straight to the result, as does a dropped sample; a
// stored sample takes up to 3 rollover steps, a multiply, an add and a check
// for the mean and a 39-step serial divider, skipped when the mean saturates;
// a percentile query on a nonempty histogram scans the buckets, then interpolates bit-serially.
// The max_delay_ms limit register may be written on the cfg channel only
// while no command is outstanding.
`default_nettype none
module latency_histogram_percentile (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_delay_ms,
  input  wire logic [3:0]  in_bucket_index,
  input  wire logic [13:0] in_pct_hundredths,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [30:0] cfg_max_delay_ms,
  output logic             out_valid,
  output logic             out_accepted,
  output logic [31:0]      out_sample_count,
  output logic [30:0]      out_min_delay,
  output logic [30:0]      out_max_delay,
  output logic [29:0]      out_sum_low_part,
  output logic [31:0]      out_sum_high_part,
  output logic [31:0]      out_bucket_count,
  output logic [12:0]      out_bucket_upper,
  output logic [38:0]      out_percentile_value,
  output logic [38:0]      out_mean_value
);

  logic          q_full;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;
  lhp_pkg::cmd_t push_cmd;
  lhp_pkg::cmd_t head_cmd;

  lhp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_delay_ms       (in_delay_ms),
    .in_bucket_index   (in_bucket_index),
    .in_pct_hundredths (in_pct_hundredths),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_delay_ms  (cfg_max_delay_ms),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (push_cmd)
  );

  lhp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .head     (head_cmd)
  );

  lhp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_cmd                (head_cmd),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_accepted         (out_accepted),
    .out_sample_count     (out_sample_count),
    .out_min_delay        (out_min_delay),
    .out_max_delay        (out_max_delay),
    .out_sum_low_part     (out_sum_low_part),
    .out_sum_high_part    (out_sum_high_part),
    .out_bucket_count     (out_bucket_count),
    .out_bucket_upper     (out_bucket_upper),
    .out_percentile_value (out_percentile_value),
    .out_mean_value       (out_mean_value)
  );

endmodule
`default_nettype wire

>>> tb/latency_histogram_percentile_check.sv
// checker for the latency histogram: tracks beats, predicts results and compares them
`timescale 1ns / 100ps
module latency_histogram_percentile_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_delay_ms,
  input  logic [3:0]  in_bucket_index,
  input  logic [13:0] in_pct_hundredths,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [30:0] cfg_max_delay_ms,
  input  logic        out_valid,
  input  logic        out_accepted,
  input  logic [31:0] out_sample_count,
  input  logic [30:0] out_min_delay,
  input  logic [30:0] out_max_delay,
  input  logic [29:0] out_sum_low_part,
  input  logic [31:0] out_sum_high_part,
  input  logic [31:0] out_bucket_count,
  input  logic [12:0] out_bucket_upper,
  input  logic [38:0] out_percentile_value,
  input  logic [38:0] out_mean_value,
  output int          errors,
  output int          pending,
  output int          results_seen
);

  typedef struct {
    bit          acc;
    bit [31:0]   cnt;
    bit [30:0]   mn;
    bit [30:0]   mx;
    bit [29:0]   sum_lo;
    bit [31:0]   sum_hi;
    bit [31:0]   bcnt;
    bit [12:0]   bup;
    bit [38:0]   pval;
    bit [38:0]   mean;
  } hist_result_t;

  localparam bit [63:0] ONE_BILLION = 64'd1000000000;
  localparam bit [63:0] FULL_PCT = 64'd10000;
  localparam bit [63:0] COUNT_SAT = 64'hFFFF_FFFF;

  bit [63:0] edges [lhp_pkg::NUM_BUCKETS] =
    '{1, 2, 5, 10, 25, 50, 100, 250, 500, 1000, 2500, 5000, 0};

  bit [63:0] limit_ms;
  bit [63:0] counts [lhp_pkg::NUM_BUCKETS];
  bit [63:0] total, min_ms, max_ms, sum_lo, sum_hi;
  hist_result_t expected_q[$];

  function automatic bit [63:0] scaled_frac(bit [63:0] w, bit [63:0] num, bit [63:0] den);
    bit [63:0] res, r;
    res = 0;
    r = 0;
    for (int b = 38; b >= 0; b--) begin
      res = res << 1;
      r = r << 1;
      while (r >= den) begin
        r -= den;
        res++;
      end
      if (w[b]) begin
        r += num;
        while (r >= den) begin
          r -= den;
          res++;
        end
      end
    end
    return res;
  endfunction

  function automatic bit [63:0] mean_ms();
    bit [63:0] s, q, r;
    if (total == 0) return 0;
    s = sum_hi * ONE_BILLION + sum_lo;
    q = s / total;
    r = s % total;
    if (q >= 64'h8000_0000) return {25'd0, lhp_pkg::MAX39};
    return (q << 8) + ((r << 8) / total);
  endfunction

  function automatic bit [63:0] percentile_ms(bit [63:0] p);
    bit [63:0] target, cum, c, lo, hi, den, base, num;
    if (total == 0) return 0;
    if (p > FULL_PCT) p = FULL_PCT;
    target = total * p;
    cum = 0;
    for (int i = 0; i < lhp_pkg::NUM_BUCKETS; i++) begin
      c = counts[i];
      if (c != 0) begin
        if ((cum + c) * FULL_PCT >= target) begin
          lo = (i == 0) ? 0 : edges[i - 1];
          hi = (edges[i] != 0) ? edges[i] : max_ms;
          den = c * FULL_PCT;
          base = cum * FULL_PCT;
          if (lo < min_ms) lo = min_ms;
          if (hi > max_ms) hi = max_ms;
          if (hi < lo) hi = lo;
          num = (target > base) ? target - base : 0;
          if (num > den) num = den;
          return (lo << 8) + scaled_frac((hi - lo) << 8, num, den);
        end
        cum += c;
      end
    end
    return max_ms << 8;
  endfunction

  function automatic void clear_hist();
    foreach (counts[i]) counts[i] = 0;
    total = 0;
    min_ms = 0;
    max_ms = 0;
    sum_lo = 0;
    sum_hi = 0;
  endfunction

  function automatic hist_result_t apply_command(lhp_pkg::op_t kind, bit [31:0] ms,
                                                 bit [3:0] idx, bit [13:0] pct);
    hist_result_t res;
    int b;
    bit [63:0] s;
    bit [63:0] v;
    bit [63:0] ms64;
    res = '{default: 0};
    ms64 = {32'd0, ms};
    case (kind)
      lhp_pkg::OP_REC: begin
        if (ms64 <= limit_ms) begin
          b = lhp_pkg::NUM_BUCKETS - 1;
          for (int i = lhp_pkg::NUM_BUCKETS - 2; i >= 0; i--) if (ms64 <= edges[i]) b = i;
          if (counts[b] < COUNT_SAT) counts[b]++;
          if (total == 0 || ms64 < min_ms) min_ms = ms64;
          if (ms64 > max_ms) max_ms = ms64;
          s = sum_lo + ms64;
          sum_lo = s % ONE_BILLION;
          sum_hi += s / ONE_BILLION;
          if (sum_hi > COUNT_SAT) sum_hi = COUNT_SAT;
          if (total < COUNT_SAT) total++;
          res.acc = 1'b1;
        end
      end
      lhp_pkg::OP_CLR: clear_hist();
      lhp_pkg::OP_RD: begin
        if (idx < 4'(lhp_pkg::NUM_BUCKETS)) begin
          res.bcnt = counts[idx][31:0];
          res.bup = edges[idx][12:0];
        end
      end
      default: begin
        v = percentile_ms({50'd0, pct});
        res.pval = v[38:0];
      end
    endcase
    res.cnt = total[31:0];
    res.mn = (total != 0) ? min_ms[30:0] : 31'd0;
    res.mx = max_ms[30:0];
    res.sum_lo = sum_lo[29:0];
    res.sum_hi = sum_hi[31:0];
    v = mean_ms();
    res.mean = v[38:0];
    return res;
  endfunction

  function automatic void compare_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d", results_seen, name,
                 exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    hist_result_t e;
    if (!rst_n) begin
      limit_ms = {33'd0, lhp_pkg::RESET_MAX};
      clear_hist();
      expected_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result beat with nothing expected");
        end else begin
          e = expected_q.pop_front();
          compare_field("accepted", 64'(e.acc), 64'(out_accepted));
          compare_field("sample_count", 64'(e.cnt), 64'(out_sample_count));
          compare_field("min_delay", 64'(e.mn), 64'(out_min_delay));
          compare_field("max_delay", 64'(e.mx), 64'(out_max_delay));
          compare_field("sum_low_part", 64'(e.sum_lo), 64'(out_sum_low_part));
          compare_field("sum_high_part", 64'(e.sum_hi), 64'(out_sum_high_part));
          compare_field("bucket_count", 64'(e.bcnt), 64'(out_bucket_count));
          compare_field("bucket_upper", 64'(e.bup), 64'(out_bucket_upper));
          compare_field("percentile_value", 64'(e.pval), 64'(out_percentile_value));
          compare_field("mean_value", 64'(e.mean), 64'(out_mean_value));
        end
        results_seen++;
      end
      if (start && !busy)
        expected_q.push_back(apply_command(lhp_pkg::op_t'(in_kind), in_delay_ms,
                                           in_bucket_index, in_pct_hundredths));
      if (cfg_valid && cfg_ready) limit_ms = {33'd0, cfg_max_delay_ms};
    end
    pending <= expected_q.size();
  end

endmodule

>>> tb/latency_histogram_percentile_test.sv
// top of the latency histogram testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module latency_histogram_percentile_test;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [31:0] in_delay_ms;
  logic [3:0]  in_bucket_index;
  logic [13:0] in_pct_hundredths;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_max_delay_ms;
  logic        out_valid;
  logic        out_accepted;
  logic [31:0] out_sample_count;
  logic [30:0] out_min_delay;
  logic [30:0] out_max_delay;
  logic [29:0] out_sum_low_part;
  logic [31:0] out_sum_high_part;
  logic [31:0] out_bucket_count;
  logic [12:0] out_bucket_upper;
  logic [38:0] out_percentile_value;
  logic [38:0] out_mean_value;
  int          errors;
  int          pending;
  int          results_seen;
  int          idle_pct;
  int          sent;

  latency_histogram_percentile dut (.*);
  latency_histogram_percentile_check checker_i (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  task automatic send_beat(lhp_pkg::op_t kind, bit [31:0] ms, bit [3:0] idx, bit [13:0] pct);
    start <= 1'b1;
    in_kind <= kind;
    in_delay_ms <= ms;
    in_bucket_index <= idx;
    in_pct_hundredths <= pct;
    do @(posedge clk); while (busy);
    sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(bit [30:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_max_delay_ms <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [31:0] pick_delay();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(0, 6000);
      4, 5: return $urandom_range(0, 30);
      6: return $urandom_range(0, 4000000);
      7: return $urandom_range(0, 32'h7FFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_beat();
    int r;
    r = $urandom_range(99);
    if (r < 70) send_beat(lhp_pkg::OP_REC, pick_delay(), 4'($urandom), 14'($urandom));
    else if (r < 82) send_beat(lhp_pkg::OP_RD, $urandom, 4'($urandom), 14'($urandom));
    else if (r < 97)
      send_beat(lhp_pkg::OP_PCT, $urandom, 4'($urandom),
                ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000)));
    else send_beat(lhp_pkg::OP_CLR, $urandom, 4'($urandom), 14'($urandom));
  endtask

  initial begin
    bit [30:0] limits [5];
    int phase_idle [5];
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = lhp_pkg::OP_REC;
    in_delay_ms = '0;
    in_bucket_index = '0;
    in_pct_hundredths = '0;
    cfg_valid = 1'b0;
    cfg_max_delay_ms = '0;
    idle_pct = 0;
    sent = 0;
    limits = '{lhp_pkg::RESET_MAX, 31'd0, 31'h7FFF_FFFF, 31'd5000, 31'($urandom)};
    phase_idle = '{0, 80, 27, 0, 80};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty histogram, bucket edges, drop at default limit
    send_beat(lhp_pkg::OP_PCT, 32'd0, 4'd0, 14'd5000);
    send_beat(lhp_pkg::OP_RD, 32'd0, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'd0, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'd1, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'd2, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'd6, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'd5000, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'd5001, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'd3600000, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'd3600001, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_PCT, 32'd0, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_PCT, 32'd0, 4'd0, 14'd16383);
    send_beat(lhp_pkg::OP_RD, 32'd0, 4'd12, 14'd0);
    send_beat(lhp_pkg::OP_RD, 32'd0, 4'd13, 14'd0);
    send_beat(lhp_pkg::OP_CLR, 32'd0, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_PCT, 32'd0, 4'd0, 14'd10000);

    // widest limit: sum rolls past one billion more than once
    write_limit(31'h7FFF_FFFF);
    send_beat(lhp_pkg::OP_REC, 32'h7FFF_FFFF, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'h7FFF_FFFF, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'h8000_0000, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'hFFFF_FFFF, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_REC, 32'd3, 4'd0, 14'd0);
    send_beat(lhp_pkg::OP_PCT, 32'd0, 4'd0, 14'd9999);
    send_beat(lhp_pkg::OP_PCT, 32'd0, 4'd0, 14'd1);
    send_beat(lhp_pkg::OP_RD, 32'd0, 4'd15, 14'd0);
    send_beat(lhp_pkg::OP_RD, 32'd0, 4'd11, 14'd0);

    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      idle_pct = phase_idle[ph];
      if (ph == 3) send_beat(lhp_pkg::OP_CLR, 32'd0, 4'd0, 14'd0);
      repeat (76) random_beat();
    end

    drain();
    $display("%0d commands sent, %0d results checked over five limit settings and idle mixes",
             sent, results_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lhp_pkg.sv
rtl/core/lhp_front.sv
rtl/core/lhp_queue.sv
rtl/core/lhp_back.sv
rtl/core/latency_histogram_percentile.sv
tb/latency_histogram_percentile_check.sv
tb/latency_histogram_percentile_test.sv
